// ===== rtl/sac_pkg.sv =====
// Shared constants, types and helper functions of the set-associative cache.
package sac_pkg;

  localparam int MAX_SETS  = 256;
  localparam int MAX_WAYS  = 8;
  localparam int ADDR_BITS = 48;

  localparam int SET_W        = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int MAX_SET_BITS = $clog2(MAX_SETS + 1) - 1;
  localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_CNT_W    = $clog2(MAX_WAYS + 1);
  localparam int TREE_LVLS    = $clog2(MAX_WAYS);
  localparam int TREE_LEAVES  = 1 << TREE_LVLS;
  localparam int LVL_W        = (TREE_LVLS > 0) ? $clog2(TREE_LVLS + 1) : 1;
  localparam int TAG_W        = ADDR_BITS;
  localparam int STAMP_W      = 64;
  localparam int CNT_W        = 32;
  localparam int OUT_WAY_W    = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 4;
  localparam int SHIFT_W      = 5;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY   = 2'd0,
    CFG_OFFSET   = 2'd1,
    CFG_SET_BITS = 2'd2,
    CFG_WAYS     = 2'd3
  } cfg_idx_t;

  localparam logic       POLICY_RST   = 1'b0;
  localparam logic [3:0] OFFSET_RST   = 4'd6;
  localparam logic [3:0] SET_BITS_RST = 4'd0;
  localparam logic [3:0] WAYS_RST     = 4'd1;

  typedef struct packed {
    logic       policy;
    logic [3:0] offset_bits;
    logic [3:0] set_bits;
    logic [3:0] ways;
  } cfg_t;

  typedef struct packed {
    logic             cmd;
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;
  } req_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0]              valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp;
  } row_t;

  typedef struct packed {
    logic               elig;
    logic [WAY_W-1:0]   way;
    logic [STAMP_W-1:0] stamp;
  } cand_t;

  function automatic logic [3:0] sat_set_bits(input logic [3:0] sb);
    return (int'(sb) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : sb;
  endfunction

  function automatic logic [WAY_CNT_W-1:0] sat_ways(input logic [3:0] w);
    logic [WAY_CNT_W-1:0] n;
    if (w == 4'd0) begin
      n = WAY_CNT_W'(1);
    end else if (int'(w) > MAX_WAYS) begin
      n = WAY_CNT_W'(MAX_WAYS);
    end else begin
      n = WAY_CNT_W'(w);
    end
    return n;
  endfunction

  // Keeps the smaller stamp; on a tie the higher way (b) wins.
  function automatic cand_t pick_min(input cand_t a, input cand_t b);
    cand_t r;
    if (a.elig && b.elig) begin
      r = (b.stamp <= a.stamp) ? b : a;
    end else if (b.elig) begin
      r = b;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

// ===== rtl/set_assoc_cache_fifo_lru.sv =====
// Top level of the set-associative cache model with FIFO or LRU replacement.
//
// This block models a write-through, write-allocate set-associative cache of up to
// 256 sets by 8 ways and reports, for each read or write access, whether it hit,
// whether it caused a memory fetch or store, which way it used, and the running hit,
// miss, fetch and store counts. The front end splits the address into set index and
// tag and drops the request into a two-entry queue; the back end works on one access
// at a time against a single-port set memory that holds the tags, valid flags and
// stamps of a whole set in one row. An access that hits, or misses into a free way,
// passes in the back end through row read, tag compare, and row write with result;
// a miss into a full set adds a victim search over the levels of the stamp tree
// between compare and write. The set memory needs no clearing pass after reset: a
// flag per set marks rows never written, and such a row reads as empty. A result is
// held in an output register until it is transferred, while the queue keeps taking
// new accesses until it is full. Configuration writes are always ready and are
// to be made only while no access is in flight; changing them keeps the cache
// contents and the counters.
module set_assoc_cache_fifo_lru (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [sac_pkg::ADDR_BITS-1:0]  in_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_hit,
  output logic                           out_fetch,
  output logic                           out_store,
  output logic [sac_pkg::OUT_WAY_W-1:0]  out_way_used,
  output logic [sac_pkg::CNT_W-1:0]      out_hits_total,
  output logic [sac_pkg::CNT_W-1:0]      out_misses_total,
  output logic [sac_pkg::CNT_W-1:0]      out_fetches_total,
  output logic [sac_pkg::CNT_W-1:0]      out_stores_total
);

  sac_pkg::cfg_t cfg_r;
  sac_pkg::req_t push_data, q_head;
  logic          q_push, q_pop, q_full, q_valid;

  assign cfg_ready = 1'b1;

  // Registers keep the raw written value; saturation is applied where they are used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy      <= sac_pkg::POLICY_RST;
      cfg_r.offset_bits <= sac_pkg::OFFSET_RST;
      cfg_r.set_bits    <= sac_pkg::SET_BITS_RST;
      cfg_r.ways        <= sac_pkg::WAYS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (sac_pkg::cfg_idx_t'(cfg_index))
        sac_pkg::CFG_POLICY:   cfg_r.policy      <= cfg_data[0];
        sac_pkg::CFG_OFFSET:   cfg_r.offset_bits <= cfg_data;
        sac_pkg::CFG_SET_BITS: cfg_r.set_bits    <= cfg_data;
        sac_pkg::CFG_WAYS:     cfg_r.ways        <= cfg_data;
        default: ;
      endcase
    end
  end

  sac_front u_front (
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_cmd     (in_cmd),
    .in_address (in_address),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .q_push     (q_push),
    .q_data     (push_data)
  );

  sac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  sac_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_fetch         (out_fetch),
    .out_store         (out_store),
    .out_way_used      (out_way_used),
    .out_hits_total    (out_hits_total),
    .out_misses_total  (out_misses_total),
    .out_fetches_total (out_fetches_total),
    .out_stores_total  (out_stores_total)
  );

endmodule

// ===== rtl/sac_front.sv =====
// Front end: splits each access address into set index and tag.
module sac_front (
  input  sac_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  logic                          in_cmd,
  input  logic [sac_pkg::ADDR_BITS-1:0] in_address,
  input  logic                          q_full,
  output logic                          in_stall,
  output logic                          q_push,
  output sac_pkg::req_t                 q_data
);

  logic [3:0]                    sb;
  logic [sac_pkg::ADDR_BITS-1:0] off_addr;
  logic [sac_pkg::SET_W-1:0]     set_mask;
  logic [sac_pkg::SHIFT_W-1:0]   tag_sh;

  always_comb begin
    sb       = sac_pkg::sat_set_bits(cfg.set_bits);
    off_addr = in_address >> cfg.offset_bits;
    set_mask = ~({sac_pkg::SET_W{1'b1}} << sb);
    tag_sh   = {1'b0, cfg.offset_bits} + {1'b0, sb};

    q_data.cmd     = in_cmd;
    q_data.set_idx = off_addr[sac_pkg::SET_W-1:0] & set_mask;
    q_data.tag     = sac_pkg::TAG_W'(in_address >> tag_sh);
  end

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

endmodule

// ===== rtl/sac_queue.sv =====
// Short request queue between the front end and the lookup engine.
module sac_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sac_pkg::req_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output sac_pkg::req_t head
);

  sac_pkg::req_t               ent_r [sac_pkg::QUEUE_DEPTH];
  logic [sac_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [sac_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [sac_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == sac_pkg::QCNT_W'(sac_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sac_pkg::QPTR_W'(sac_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == sac_pkg::QPTR_W'(sac_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/sac_back.sv =====
// Lookup engine: set memory, hit and victim search, counters and result register.
module sac_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sac_pkg::cfg_t                  cfg,
  input  logic                           q_valid,
  input  sac_pkg::req_t                  q_head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_hit,
  output logic                           out_fetch,
  output logic                           out_store,
  output logic [sac_pkg::OUT_WAY_W-1:0]  out_way_used,
  output logic [sac_pkg::CNT_W-1:0]      out_hits_total,
  output logic [sac_pkg::CNT_W-1:0]      out_misses_total,
  output logic [sac_pkg::CNT_W-1:0]      out_fetches_total,
  output logic [sac_pkg::CNT_W-1:0]      out_stores_total
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TAG  = 4'b0010,
    S_MIN  = 4'b0100,
    S_UPD  = 4'b1000
  } bk_state_t;

  bk_state_t state_r, state_nxt;

  sac_pkg::row_t                  mem [sac_pkg::MAX_SETS];
  logic [sac_pkg::MAX_SETS-1:0]   row_valid_r;

  sac_pkg::req_t                  cur_r;
  sac_pkg::row_t                  row_r;
  logic                           rowv_r;
  logic                           hit_r;
  logic                           free_r;
  logic [sac_pkg::WAY_W-1:0]      way_r;
  sac_pkg::cand_t                 cand_r [sac_pkg::TREE_LEAVES];
  logic [sac_pkg::LVL_W-1:0]      lvl_r;

  logic [sac_pkg::STAMP_W-1:0]    stamp_cnt_r;
  logic [sac_pkg::CNT_W-1:0]      hit_cnt_r, miss_cnt_r, fetch_cnt_r, store_cnt_r;

  logic                           out_valid_r, out_hit_r, out_fetch_r, out_store_r;
  logic [sac_pkg::OUT_WAY_W-1:0]  out_way_r;

  logic [sac_pkg::WAY_CNT_W-1:0]  nw;
  logic [sac_pkg::MAX_WAYS-1:0]   en, eff_valid, hit_vec, free_vec;
  logic                           hit_any, free_any;
  logic [sac_pkg::WAY_W-1:0]      hit_way, free_way, use_way;
  logic                           rd_en, fire_upd, restamp;
  logic [sac_pkg::STAMP_W-1:0]    stamp_inc;
  sac_pkg::row_t                  new_row;

  // Tag match and free-way search on the registered set row.
  always_comb begin
    nw        = sac_pkg::sat_ways(cfg.ways);
    eff_valid = rowv_r ? row_r.valid : '0;
    hit_way   = '0;
    free_way  = '0;
    for (int w = 0; w < sac_pkg::MAX_WAYS; w++) begin
      en[w]       = (sac_pkg::WAY_CNT_W'(w) < nw);
      hit_vec[w]  = eff_valid[w] & en[w] & (row_r.tag[w] == cur_r.tag);
      free_vec[w] = ~eff_valid[w] & en[w];
    end
    for (int w = sac_pkg::MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = sac_pkg::WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_way = sac_pkg::WAY_W'(w);
      end
    end
    hit_any  = |hit_vec;
    free_any = |free_vec;
  end

  assign rd_en    = (state_r == S_IDLE) && q_valid;
  assign q_pop    = rd_en;
  assign fire_upd = (state_r == S_UPD) && (!out_valid_r || !out_stall);
  assign restamp  = !hit_r || cfg.policy;
  assign stamp_inc = stamp_cnt_r + 1'b1;
  assign use_way  = (hit_r || free_r) ? way_r : cand_r[0].way;

  // Row written back: a miss installs the tag, and a miss or an LRU hit restamps.
  always_comb begin
    new_row       = row_r;
    new_row.valid = eff_valid;
    if (restamp) begin
      new_row.stamp[use_way] = stamp_inc;
    end
    if (!hit_r) begin
      new_row.valid[use_way] = 1'b1;
      new_row.tag[use_way]   = cur_r.tag;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_TAG;
        end
      end
      S_TAG: begin
        state_nxt = (hit_any || free_any) ? S_UPD : S_MIN;
      end
      S_MIN: begin
        if (lvl_r == sac_pkg::LVL_W'(sac_pkg::TREE_LVLS)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (fire_upd) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_valid_r <= '0;
      stamp_cnt_r <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      fetch_cnt_r <= '0;
      store_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire_upd) begin
        row_valid_r[cur_r.set_idx] <= 1'b1;
        if (restamp) begin
          stamp_cnt_r <= stamp_inc;
        end
        if (hit_r) begin
          hit_cnt_r <= hit_cnt_r + 1'b1;
        end else begin
          miss_cnt_r  <= miss_cnt_r + 1'b1;
          fetch_cnt_r <= fetch_cnt_r + 1'b1;
        end
        if (cur_r.cmd) begin
          store_cnt_r <= store_cnt_r + 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Set memory: one row per set, read on issue, written once per access.
  always_ff @(posedge clk) begin
    if (fire_upd) begin
      mem[cur_r.set_idx] <= new_row;
    end
    if (rd_en) begin
      row_r <= mem[q_head.set_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_r  <= q_head;
      rowv_r <= row_valid_r[q_head.set_idx];
    end
    if (state_r == S_TAG) begin
      hit_r  <= hit_any;
      free_r <= free_any;
      way_r  <= hit_any ? hit_way : free_way;
      lvl_r  <= '0;
      for (int i = 0; i < sac_pkg::TREE_LEAVES; i++) begin
        cand_r[i].way <= sac_pkg::WAY_W'(i);
        if (i < sac_pkg::MAX_WAYS) begin
          cand_r[i].elig  <= en[i];
          cand_r[i].stamp <= row_r.stamp[i];
        end else begin
          cand_r[i].elig  <= 1'b0;
          cand_r[i].stamp <= '0;
        end
      end
    end
    if (state_r == S_MIN && lvl_r != sac_pkg::LVL_W'(sac_pkg::TREE_LVLS)) begin
      lvl_r <= lvl_r + 1'b1;
      for (int i = 0; i < sac_pkg::TREE_LEAVES / 2; i++) begin
        cand_r[i] <= sac_pkg::pick_min(cand_r[2*i], cand_r[2*i+1]);
      end
    end
    if (fire_upd) begin
      out_hit_r   <= hit_r;
      out_fetch_r <= !hit_r;
      out_store_r <= cur_r.cmd;
      out_way_r   <= sac_pkg::OUT_WAY_W'(use_way);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_fetch         = out_fetch_r;
  assign out_store         = out_store_r;
  assign out_way_used      = out_way_r;
  // Counters change only when a new result is loaded, so they track the result.
  assign out_hits_total    = hit_cnt_r;
  assign out_misses_total  = miss_cnt_r;
  assign out_fetches_total = fetch_cnt_r;
  assign out_stores_total  = store_cnt_r;

endmodule
